// ----- design/f12ccw_pkg.sv -----
// Shared types, constants and register indexes of the FAT12 cluster chain walker.
`timescale 1ns / 1ps
package f12ccw_pkg;

  // FAT store size in bytes; the store is split into an even and an odd byte bank
  localparam int unsigned FatBytes  = 8192;
  localparam int unsigned FatAw     = $clog2(FatBytes);
  localparam int unsigned BankDepth = FatBytes / 2;
  localparam int unsigned BankAw    = FatAw - 1;

  // Commands
  localparam logic [1:0] CmdWrite   = 2'd0;
  localparam logic [1:0] CmdStart   = 2'd1;
  localparam logic [1:0] CmdAdvance = 2'd2;

  // Result status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StEnd     = 2'd1;
  localparam logic [1:0] StInvalid = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CfgHidden     = 3'd0;
  localparam logic [2:0] CfgReserved   = 3'd1;
  localparam logic [2:0] CfgFatCount   = 3'd2;
  localparam logic [2:0] CfgFatSectors = 3'd3;
  localparam logic [2:0] CfgRootEnt    = 3'd4;
  localparam logic [2:0] CfgSecLog2    = 3'd5;
  localparam logic [2:0] CfgSecPerClus = 3'd6;

  // FAT12 entry values
  localparam logic [11:0] EntryLastData = 12'hFEF;
  localparam logic [11:0] FirstCluster  = 12'd2;

  typedef struct packed {
    logic [31:0] hidden_sectors;
    logic [15:0] reserved_sectors;
    logic [2:0]  fat_count;
    logic [15:0] fat_sectors;
    logic [15:0] root_entries;
    logic [3:0]  sector_size_log2;
    logic [7:0]  sectors_per_cluster;
  } cfg_t;

  typedef struct packed {
    logic        vld;
    logic [11:0] cluster;
  } lba_req_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] lba;
  } lba_rsp_t;

endpackage

// ----- design/fat12_cluster_chain_walker.sv -----
// Top level: FAT12 byte store, chain state and command sequencer.
//
//  Channel  Signals                                               Handshake
//  -------  ----------------------------------------------------  -----------------------
//  command  cmd_i byte_addr_i byte_value_i start_cluster_i        start_i & !busy_o
//  result   chain_cluster_o sector_lba_o status_o                 done_o, one cycle
//  config   cfg_idx_i cfg_wdata_i                                  cfg_we_i
//
//  A write or an at-once rejected command gives its result transaction in the cycle after
//  acceptance; a start passes through ST_LBA and ST_FIN, an advance that reaches an end or
//  free entry through ST_READ, and any other advance through ST_READ (store read), ST_LBA and ST_FIN.
//  busy_o is high while a start or advance is in flight.
//  The FAT store is two byte banks (even/odd addresses) so both entry bytes are read
//  together; it has no reset. Results cannot be stalled and are never held back.
`timescale 1ns / 1ps
module fat12_cluster_chain_walker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [12:0] byte_addr_i,
  input  logic [7:0]  byte_value_i,
  input  logic [11:0] start_cluster_i,
  output logic        done_o,
  output logic [11:0] chain_cluster_o,
  output logic [31:0] sector_lba_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);
  import f12ccw_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LBA,
    ST_FIN
  } state_e;

  state_e      state_q;
  logic [11:0] cc_q;
  logic        active_q;
  logic        off_odd_q;
  logic        done_q;
  logic [11:0] clus_out_q;
  logic [31:0] lba_out_q;
  logic [1:0]  status_q;
  cfg_t        cfg_q;

  logic        accept;
  logic [31:0] waddr32;
  logic        wr_ok;
  logic [31:0] off32;
  logic [31:0] off_p1;
  logic        off_ovf;
  logic        we_even, we_odd;
  logic [BankAw-1:0] waddr_bank;
  logic [BankAw-1:0] raddr_even, raddr_odd;
  logic [7:0]  rd_even, rd_odd;
  logic [7:0]  lo_byte, hi_byte;
  logic [15:0] word;
  logic [11:0] entry;
  lba_req_t    lba_req;
  lba_rsp_t    lba_rsp;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);

  // Store write decode
  assign waddr32    = 32'(byte_addr_i);
  assign wr_ok      = (waddr32 < FatBytes);
  assign we_even    = accept && (cmd_i == CmdWrite) && wr_ok && !byte_addr_i[0];
  assign we_odd     = accept && (cmd_i == CmdWrite) && wr_ok && byte_addr_i[0];
  assign waddr_bank = waddr32[BankAw:1];

  // Entry offset = cluster * 3 / 2; low byte in the odd bank when the offset is odd
  assign off32      = 32'(cc_q) + 32'(cc_q[11:1]);
  assign off_p1     = off32 + 32'd1;
  assign off_ovf    = (off_p1 >= FatBytes);
  assign raddr_even = off_p1[BankAw:1];
  assign raddr_odd  = off32[BankAw:1];

  f12ccw_ram #(.Depth(BankDepth), .Width(8)) u_bank_even (
    .clk_i   (clk_i),
    .we_i    (we_even),
    .waddr_i (waddr_bank),
    .wdata_i (byte_value_i),
    .raddr_i (raddr_even),
    .rdata_o (rd_even)
  );

  f12ccw_ram #(.Depth(BankDepth), .Width(8)) u_bank_odd (
    .clk_i   (clk_i),
    .we_i    (we_odd),
    .waddr_i (waddr_bank),
    .wdata_i (byte_value_i),
    .raddr_i (raddr_odd),
    .rdata_o (rd_odd)
  );

  always_comb begin
    lo_byte = off_odd_q ? rd_odd : rd_even;
    hi_byte = off_odd_q ? rd_even : rd_odd;
    word    = {hi_byte, lo_byte};
    entry   = cc_q[0] ? word[15:4] : word[11:0];
  end

  assign lba_req.vld     = (state_q == ST_LBA);
  assign lba_req.cluster = cc_q;

  f12ccw_lba u_lba (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .req_i  (lba_req),
    .rsp_o  (lba_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hidden_sectors      <= 32'd0;
      cfg_q.reserved_sectors    <= 16'd1;
      cfg_q.fat_count           <= 3'd2;
      cfg_q.fat_sectors         <= 16'd9;
      cfg_q.root_entries        <= 16'd224;
      cfg_q.sector_size_log2    <= 4'd9;
      cfg_q.sectors_per_cluster <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHidden:     cfg_q.hidden_sectors      <= cfg_wdata_i;
        CfgReserved:   cfg_q.reserved_sectors    <= cfg_wdata_i[15:0];
        CfgFatCount:   cfg_q.fat_count           <= cfg_wdata_i[2:0];
        CfgFatSectors: cfg_q.fat_sectors         <= cfg_wdata_i[15:0];
        CfgRootEnt:    cfg_q.root_entries        <= cfg_wdata_i[15:0];
        CfgSecLog2:    cfg_q.sector_size_log2    <= cfg_wdata_i[3:0];
        CfgSecPerClus: cfg_q.sectors_per_cluster <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cc_q       <= 12'd0;
      active_q   <= 1'b0;
      off_odd_q  <= 1'b0;
      done_q     <= 1'b0;
      clus_out_q <= 12'd0;
      lba_out_q  <= 32'd0;
      status_q   <= StOk;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            lba_out_q  <= 32'd0;
            clus_out_q <= cc_q;
            case (cmd_i)
              CmdWrite: begin
                done_q   <= 1'b1;
                status_q <= wr_ok ? StOk : StInvalid;
              end
              CmdStart: begin
                cc_q <= start_cluster_i;
                if (start_cluster_i < FirstCluster) begin
                  active_q   <= 1'b0;
                  done_q     <= 1'b1;
                  clus_out_q <= start_cluster_i;
                  status_q   <= StInvalid;
                end else begin
                  active_q <= 1'b1;
                  state_q  <= ST_LBA;
                end
              end
              CmdAdvance: begin
                if (!active_q) begin
                  done_q   <= 1'b1;
                  status_q <= StInvalid;
                end else if (off_ovf) begin
                  active_q <= 1'b0;
                  done_q   <= 1'b1;
                  status_q <= StInvalid;
                end else begin
                  off_odd_q <= off32[0];
                  state_q   <= ST_READ;
                end
              end
              default: begin
                done_q   <= 1'b1;
                status_q <= StInvalid;
              end
            endcase
          end
        end
        ST_READ: begin
          if (entry > EntryLastData) begin
            active_q   <= 1'b0;
            done_q     <= 1'b1;
            clus_out_q <= entry;
            status_q   <= StEnd;
            state_q    <= ST_IDLE;
          end else if (entry < FirstCluster) begin
            active_q   <= 1'b0;
            done_q     <= 1'b1;
            clus_out_q <= cc_q;
            status_q   <= StInvalid;
            state_q    <= ST_IDLE;
          end else begin
            cc_q    <= entry;
            state_q <= ST_LBA;
          end
        end
        ST_LBA: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          done_q     <= 1'b1;
          clus_out_q <= cc_q;
          lba_out_q  <= lba_rsp.lba;
          status_q   <= StOk;
          state_q    <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o          = done_q;
  assign chain_cluster_o = clus_out_q;
  assign sector_lba_o    = lba_out_q;
  assign status_o        = status_q;

`ifndef SYNTHESIS
  a_write_answers_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CmdWrite) |=> done_o)
    else $error("write transaction without result on the next cycle");

  a_fail_has_no_lba: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != StOk) |-> (sector_lba_o == 32'd0))
    else $error("non-ok result carries a sector address");

  a_end_clears_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StEnd) |-> !active_q)
    else $error("end of chain left the chain active");

  a_read_needs_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> active_q)
    else $error("store read without an active chain");

  a_lba_in_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lba_rsp.vld |-> (state_q == ST_FIN))
    else $error("sector address unit out of step with the sequencer");
`endif

endmodule

// ----- design/f12ccw_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
module f12ccw_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/f12ccw_lba.sv -----
// Two-step sector address unit: first data sector plus cluster offset.
`timescale 1ns / 1ps
module f12ccw_lba (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  f12ccw_pkg::cfg_t     cfg_i,
  input  f12ccw_pkg::lba_req_t req_i,
  output f12ccw_pkg::lba_rsp_t rsp_o
);
  import f12ccw_pkg::*;

  logic [18:0] fat_prod;
  logic [20:0] root_bytes;
  logic [20:0] root_secs;
  logic [11:0] rel_clus;
  logic [31:0] first_d, first_q;
  logic [19:0] rel_d, rel_q;
  logic        vld_q;

  always_comb begin
    fat_prod   = 19'(cfg_i.fat_count) * 19'(cfg_i.fat_sectors);
    root_bytes = {cfg_i.root_entries, 5'b0};
    root_secs  = root_bytes >> cfg_i.sector_size_log2;
    first_d    = cfg_i.hidden_sectors + 32'(cfg_i.reserved_sectors)
               + 32'(fat_prod) + 32'(root_secs);
    // cluster minus two wraps within 12 bits
    rel_clus   = req_i.cluster - FirstCluster;
    rel_d      = 20'(rel_clus) * 20'(cfg_i.sectors_per_cluster);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= req_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    rel_q   <= rel_d;
  end

  assign rsp_o.vld = vld_q;
  assign rsp_o.lba = first_q + 32'(rel_q);

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the FAT12 cluster chain walker: chain walks, byte writes, volume layouts.
`timescale 1ns / 1ps
module tb_top;
  import f12ccw_pkg::*;

  localparam logic [1:0]  CmdUnused  = 2'd3;
  localparam logic [11:0] ChainEnd   = EntryLastData + 12'd1;
  localparam int          QuietLimit = 2000;
  localparam int          PhaseItems = 280;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [12:0] byte_addr;
    logic [7:0]  byte_value;
    logic [11:0] start_cluster;
  } fat_cmd_t;

  typedef struct packed {
    logic [11:0] chain_cluster;
    logic [31:0] sector_lba;
    logic [1:0]  status;
  } chain_ans_t;

  typedef struct packed {
    logic        active;
    logic [11:0] cur;
  } chain_pos_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  cmd_i = CmdWrite;
  logic [12:0] byte_addr_i = '0;
  logic [7:0]  byte_value_i = '0;
  logic [11:0] start_cluster_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CfgHidden;
  logic [31:0] cfg_wdata_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [11:0] chain_cluster_o;
  logic [31:0] sector_lba_o;
  logic [1:0]  status_o;

  fat12_cluster_chain_walker DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // volume layout as last written; only changes while nothing is in flight
  cfg_t vol = '{hidden_sectors: 32'd0, reserved_sectors: 16'd1, fat_count: 3'd2,
                fat_sectors: 16'd9, root_entries: 16'd224, sector_size_log2: 4'd9,
                sectors_per_cluster: 8'd1};

  // stimulus-side image of the table, used to keep chains well formed
  logic [7:0]  gen_fat [FatBytes];
  bit          byte_set [FatBytes];
  chain_pos_t  gen_pos = '0;
  // checking-side image, advanced on each accepted transaction
  logic [7:0]  chk_fat [FatBytes];
  chain_pos_t  chk_pos = '0;

  fat_cmd_t    fat_cmd_q [$];
  chain_ans_t  chain_answers_q [$];

  int n_items = 0;
  int n_seen = 0;
  int fails = 0;
  int n_ok = 0;
  int n_end = 0;
  int n_rej = 0;

  function automatic logic [12:0] fat_offset(input logic [11:0] clus);
    return {1'b0, clus} + {2'b00, clus[11:1]};
  endfunction

  function automatic logic [31:0] cluster_lba(input logic [11:0] clus);
    logic [63:0] first;
    logic [63:0] rel;
    first = 64'(vol.hidden_sectors) + 64'(vol.reserved_sectors)
          + 64'(vol.fat_count) * 64'(vol.fat_sectors)
          + ((64'(vol.root_entries) * 64'd32) >> vol.sector_size_log2);
    rel = 64'(12'(clus - FirstCluster)) * 64'(vol.sectors_per_cluster);
    return 32'(first + rel);
  endfunction

  // One command against the chain position; word is the 16 bits at the
  // current cluster's table offset. The caller applies byte writes itself.
  function automatic chain_ans_t walk_chain(inout chain_pos_t pos, input fat_cmd_t it,
                                            input logic [15:0] word);
    chain_ans_t ans;
    logic [11:0] entry;
    ans.chain_cluster = pos.cur;
    ans.sector_lba = '0;
    ans.status = StInvalid;
    entry = pos.cur[0] ? word[15:4] : word[11:0];
    case (it.cmd)
      CmdWrite: if (int'(it.byte_addr) < FatBytes) ans.status = StOk;
      CmdStart: begin
        pos.cur = it.start_cluster;
        ans.chain_cluster = it.start_cluster;
        pos.active = (it.start_cluster >= FirstCluster);
        if (pos.active) begin
          ans.sector_lba = cluster_lba(it.start_cluster);
          ans.status = StOk;
        end
      end
      CmdAdvance: if (pos.active) begin
        if (int'(fat_offset(pos.cur)) + 1 >= FatBytes) begin
          pos.active = 1'b0;
        end else if (entry > EntryLastData) begin
          pos.active = 1'b0;
          ans.chain_cluster = entry;
          ans.status = StEnd;
        end else if (entry < FirstCluster) begin
          pos.active = 1'b0;
        end else begin
          pos.cur = entry;
          ans.chain_cluster = entry;
          ans.sector_lba = cluster_lba(entry);
          ans.status = StOk;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic fat_cmd_t rand_cmd(input logic [1:0] op);
    fat_cmd_t it;
    it.cmd = op;
    it.byte_addr = 13'($urandom);
    it.byte_value = 8'($urandom);
    it.start_cluster = 12'($urandom);
    return it;
  endfunction

  function automatic cfg_t rand_volume(input bit wide);
    cfg_t v;
    v.hidden_sectors = $urandom;
    v.root_entries = 16'($urandom);
    v.reserved_sectors = wide ? 16'($urandom) : 16'($urandom_range(1, 65535));
    v.fat_sectors = wide ? 16'($urandom) : 16'($urandom_range(1, 65535));
    v.fat_count = wide ? 3'($urandom) : 3'($urandom_range(1, 4));
    v.sector_size_log2 = wide ? 4'($urandom) : 4'($urandom_range(9, 12));
    v.sectors_per_cluster = wide ? 8'($urandom) : 8'($urandom_range(1, 128));
    return v;
  endfunction

  task automatic push_cmd(input fat_cmd_t it);
    logic [12:0] off;
    off = fat_offset(gen_pos.cur);
    void'(walk_chain(gen_pos, it, {gen_fat[off + 13'd1], gen_fat[off]}));
    if (it.cmd == CmdWrite && int'(it.byte_addr) < FatBytes) begin
      gen_fat[it.byte_addr] = it.byte_value;
      byte_set[it.byte_addr] = 1'b1;
    end
    fat_cmd_q.push_back(it);
    n_items++;
  endtask

  task automatic put_byte(input logic [12:0] addr, input logic [7:0] val);
    fat_cmd_t it;
    it = rand_cmd(CmdWrite);
    it.byte_addr = addr;
    it.byte_value = val;
    push_cmd(it);
  endtask

  task automatic push_start(input logic [11:0] clus);
    fat_cmd_t it;
    it = rand_cmd(CmdStart);
    it.start_cluster = clus;
    push_cmd(it);
  endtask

  // rewrite one 12-bit entry, keeping the neighbor's nibble in the shared byte
  task automatic set_entry(input logic [11:0] clus, input logic [11:0] val);
    logic [12:0] off;
    logic [7:0]  lo;
    logic [7:0]  hi;
    off = fat_offset(clus);
    lo = byte_set[off] ? gen_fat[off] : 8'($urandom);
    hi = byte_set[off + 13'd1] ? gen_fat[off + 13'd1] : 8'($urandom);
    if (clus[0]) begin
      lo[7:4] = val[3:0];
      hi = val[11:4];
    end else begin
      lo = val[7:0];
      hi[3:0] = val[11:8];
    end
    put_byte(off, lo);
    put_byte(off + 13'd1, hi);
  endtask

  // an advance may only read bytes that hold data, so fill gaps first
  task automatic push_advance();
    logic [12:0] off;
    off = fat_offset(gen_pos.cur);
    if (gen_pos.active) begin
      if (!byte_set[off]) put_byte(off, 8'($urandom));
      if (!byte_set[off + 13'd1]) put_byte(off + 13'd1, 8'($urandom));
    end
    push_cmd(rand_cmd(CmdAdvance));
  endtask

  task automatic run_chain(input int hops, input logic [11:0] base, input int span);
    logic [11:0] head;
    logic [11:0] here;
    logic [11:0] nxt;
    logic [11:0] tail;
    int steps;
    head = 12'(base + $urandom_range(0, span));
    here = head;
    for (int h = 0; h < hops; h++) begin
      nxt = 12'(base + $urandom_range(0, span));
      set_entry(here, nxt);
      here = nxt;
    end
    case ($urandom_range(0, 9))
      7: tail = 12'($urandom_range(0, 1));
      8, 9: tail = 12'($urandom);
      default: tail = ChainEnd | 12'($urandom_range(0, 15));
    endcase
    set_entry(here, tail);
    push_start(head);
    steps = 0;
    // repeated clusters can close a loop, so bound the walk
    while (gen_pos.active && steps < hops + 3) begin
      push_advance();
      steps++;
    end
    if ($urandom_range(0, 3) == 0) push_advance();
  endtask

  task automatic random_phase(input int count);
    int stop;
    int span;
    logic [11:0] base;
    stop = n_items + count;
    while (n_items < stop) begin
      if ($urandom_range(0, 99) < 65) begin
        span = $urandom_range(0, 1) ? 15 : 4093;
        base = 12'($urandom_range(2, 4095 - span));
        run_chain($urandom_range(0, 12), base, span);
      end else begin
        case ($urandom_range(0, 8))
          0, 1, 2: push_cmd(rand_cmd(CmdWrite));
          3, 4: push_start(($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 1))
                                                        : 12'($urandom));
          5, 6, 7: push_advance();
          default: push_cmd(rand_cmd(CmdUnused));
        endcase
      end
    end
  endtask

  task automatic settle();
    while (n_seen < n_items) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] data;
    data = val;
    // junk above the register width must be dropped
    case (idx)
      CfgHidden: vol.hidden_sectors = val;
      CfgReserved: begin
        vol.reserved_sectors = val[15:0];
        data[31:16] = 16'($urandom);
      end
      CfgFatCount: begin
        vol.fat_count = val[2:0];
        data[31:3] = 29'($urandom);
      end
      CfgFatSectors: begin
        vol.fat_sectors = val[15:0];
        data[31:16] = 16'($urandom);
      end
      CfgRootEnt: begin
        vol.root_entries = val[15:0];
        data[31:16] = 16'($urandom);
      end
      CfgSecLog2: begin
        vol.sector_size_log2 = val[3:0];
        data[31:4] = 28'($urandom);
      end
      CfgSecPerClus: begin
        vol.sectors_per_cluster = val[7:0];
        data[31:8] = 24'($urandom);
      end
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
  endtask

  task automatic load_volume(input cfg_t v);
    settle();
    write_reg(CfgHidden, v.hidden_sectors);
    write_reg(CfgReserved, 32'(v.reserved_sectors));
    write_reg(CfgFatCount, 32'(v.fat_count));
    write_reg(CfgFatSectors, 32'(v.fat_sectors));
    write_reg(CfgRootEnt, 32'(v.root_entries));
    write_reg(CfgSecLog2, 32'(v.sector_size_log2));
    write_reg(CfgSecPerClus, 32'(v.sectors_per_cluster));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed();
    push_advance();                 // no chain yet
    push_cmd(rand_cmd(CmdUnused));
    push_start(12'd0);
    push_start(12'd1);
    push_advance();                 // chain dropped by the bad start
    put_byte(13'd0, 8'h00);
    put_byte(13'h1FFF, 8'hFF);
    // 2 -> 3 -> 4094 -> 4095 -> 4079 -> end; neighbors share bytes
    set_entry(12'd2, 12'd3);
    set_entry(12'd3, 12'd4094);
    set_entry(12'd4094, 12'd4095);
    set_entry(12'd4095, EntryLastData);
    set_entry(EntryLastData, ChainEnd);
    push_start(12'd2);
    repeat (5) push_advance();
    push_advance();                 // past the end
    set_entry(12'd5, 12'd1);
    push_start(12'd5);
    push_advance();                 // entry below the first cluster in the chain
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    directed();
    random_phase(PhaseItems);
    load_volume(cfg_t'{32'd0, 16'd1, 3'd1, 16'd1, 16'd0, 4'd9, 8'd1});
    random_phase(PhaseItems);
    load_volume(cfg_t'{32'hFFFF_FFFF, 16'hFFFF, 3'd4, 16'hFFFF, 16'hFFFF, 4'd12, 8'd128});
    random_phase(PhaseItems);
    load_volume(rand_volume(1'b0));
    random_phase(PhaseItems);
    load_volume(rand_volume(1'b1));
    random_phase(PhaseItems);
    load_volume(rand_volume(1'b0));
    random_phase(PhaseItems);
    settle();
    if (chain_answers_q.size() != 0) begin
      $error("%0d expected results never arrived", chain_answers_q.size());
      fails++;
    end
    $display("Checked %0d results from %0d commands: %0d ok, %0d end of chain, %0d rejected",
             n_seen, n_items, n_ok, n_end, n_rej);
    $display("Six volume layouts, from the smallest to wrapping sector addresses");
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // command driver: bursts of transactions separated by random idle stretches
  fat_cmd_t    on_bus = '0;
  logic [12:0] bus_off;
  int          burst_left = 1;
  int          idle_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        bus_off = fat_offset(chk_pos.cur);
        chain_answers_q.push_back(walk_chain(chk_pos, on_bus,
                                             {chk_fat[bus_off + 13'd1], chk_fat[bus_off]}));
        if (on_bus.cmd == CmdWrite && int'(on_bus.byte_addr) < FatBytes) begin
          chk_fat[on_bus.byte_addr] = on_bus.byte_value;
        end
      end
      if (!start_i || !busy_o) begin
        if (idle_left > 0) begin
          idle_left--;
          start_i <= 1'b0;
        end else if (fat_cmd_q.size() > 0) begin
          on_bus = fat_cmd_q.pop_front();
          cmd_i <= on_bus.cmd;
          byte_addr_i <= on_bus.byte_addr;
          byte_value_i <= on_bus.byte_value;
          start_cluster_i <= on_bus.start_cluster;
          start_i <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 30);
            if ($urandom_range(0, 3) == 0) idle_left = 0;
            else if ($urandom_range(0, 9) == 0) idle_left = $urandom_range(15, 40);
            else idle_left = $urandom_range(1, 6);
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: every strobe pairs with the oldest pending expectation
  chain_ans_t want;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_seen++;
      if (chain_answers_q.size() == 0) begin
        $error("unexpected result transaction: cluster %0d lba %0h status %0d",
               chain_cluster_o, sector_lba_o, status_o);
        fails++;
      end else begin
        want = chain_answers_q.pop_front();
        case (want.status)
          StOk: n_ok++;
          StEnd: n_end++;
          default: n_rej++;
        endcase
        if (chain_cluster_o !== want.chain_cluster) begin
          $error("chain_cluster: expected %0d, got %0d", want.chain_cluster, chain_cluster_o);
          fails++;
        end
        if (sector_lba_o !== want.sector_lba) begin
          $error("sector_lba: expected %0h, got %0h", want.sector_lba, sector_lba_o);
          fails++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fails++;
        end
      end
    end
  end

  // hang detection: end the run after a long stretch with no transaction
  int quiet = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        quiet <= 0;
      end else if (quiet >= QuietLimit) begin
        $display("Timeout: no transaction for %0d cycles, %0d results pending",
                 quiet, chain_answers_q.size());
        $display("Some tests failed");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

endmodule

// ----- sim.f -----
design/f12ccw_pkg.sv
design/f12ccw_ram.sv
design/f12ccw_lba.sv
design/fat12_cluster_chain_walker.sv
tb/tb_top.sv
